[rtl/load_cell_weight_conditioner_defines.svh]
// assertion macros used by the checker file
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef LOAD_CELL_WEIGHT_CONDITIONER_DEFINES_SVH
`define LOAD_CELL_WEIGHT_CONDITIONER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LCWC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lcwc_pkg.sv]
// types and constants of the load cell weight conditioner
// no dependencies
package lcwc_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned GAIN_W   = 32;
  localparam int unsigned THR_W    = 23;
  localparam int unsigned MAG_W    = 24;
  localparam int unsigned ACC_W    = 28;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET = 32'h0100_0000;
  localparam logic [SAMPLE_W-1:0] SAT_POS    = 24'h7F_FFFF;
  localparam logic [SAMPLE_W-1:0] SAT_NEG    = 24'h80_0000;
  localparam logic signed [SAMPLE_W-1:0] DEAD_HI = 24'sd128;
  localparam logic signed [SAMPLE_W-1:0] DEAD_LO = -24'sd128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_RECIP = 2'd0,
    REG_REF_A      = 2'd1,
    REG_REF_B      = 2'd2,
    REG_TAKE_THR   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                req_type;
    logic                channel;
    logic [SAMPLE_W-1:0] raw_sample;
    logic                timed_out;
    logic                ir_level;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] weight;
    logic                       take_detected;
    logic                       tare_done;
  } out_item_t;

endpackage

[rtl/load_cell_weight_conditioner.sv]
// Load cell weight conditioner: per-channel tare, reciprocal gain scaling, dead zone and
// two-tap average, take detection, and tare averaging over TARE_SAMPLES reads. One item in,
// one result out. A weigh item passes through setup, the 24 shift-add steps of the
// multiplier, rounding, filter and output; a timed-out weigh item goes from setup straight
// to output. A tare item goes to output directly, unless it closes a run with good reads, in
// which case the 28 restoring division steps and the offset write come first. Multiplier and
// divider share one 33-bit adder. The next item is taken once the result is in the output
// register; a result waits there, and the next item is taken while it waits. No clearing
// pass after reset. Config writes are taken every cycle.
// Depends on lcwc_pkg.
module load_cell_weight_conditioner #(
  parameter int unsigned CHANNELS     = 2,
  parameter int unsigned TARE_SAMPLES = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  lcwc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output lcwc_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcwc_pkg::GAIN_W-1:0]         cfg_data
);

  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SW   = lcwc_pkg::SAMPLE_W;
  localparam int unsigned MW   = lcwc_pkg::MAG_W;
  localparam int unsigned AW   = lcwc_pkg::ACC_W;
  localparam int unsigned CW   = lcwc_pkg::CNT_W;
  localparam int unsigned PW   = lcwc_pkg::GAIN_W + lcwc_pkg::MAG_W;
  localparam int unsigned RW   = PW - 16;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_PREP = 9'b000000010,
    S_MUL  = 9'b000000100,
    S_RND  = 9'b000001000,
    S_FILT = 9'b000010000,
    S_OUT  = 9'b000100000,
    S_TACC = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_TWR  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [lcwc_pkg::GAIN_W-1:0] gain_r;
  logic signed [SW-1:0]        ref_a_r, ref_b_r;
  logic [lcwc_pkg::THR_W-1:0]  thr_r;

  // per-channel state
  logic [SW-1:0]        offset_r   [CHANNELS];
  logic [SW-1:0]        offset_nxt [CHANNELS];
  logic signed [SW-1:0] smooth_r   [CHANNELS];
  logic signed [SW-1:0] smooth_nxt [CHANNELS];
  logic [CHANNELS-1:0]  seeded_r, seeded_nxt;

  // tare run
  logic [AW-1:0] accum_r, accum_nxt;
  logic [CW-1:0] good_r, good_nxt;
  logic [CW-1:0] seen_r, seen_nxt;

  // datapath
  lcwc_pkg::in_item_t         item_r, item_nxt;
  logic [lcwc_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [lcwc_pkg::GAIN_W-1:0] hi_r, hi_nxt;
  logic [MW-1:0]               lo_r, lo_nxt;
  logic                        neg_r, neg_nxt;
  logic [CW-1:0]               rem_r, rem_nxt;
  logic signed [SW-1:0]        scaled_r, scaled_nxt;
  logic signed [SW-1:0]        res_w_r, res_w_nxt;
  logic                        done_r, done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  lcwc_pkg::out_item_t         out_data_r, out_data_nxt;

  // shared adder
  logic [32:0] add_a, add_b;
  logic        add_cin;
  logic [33:0] add_sum;

  logic [CH_W-1:0]      ch_idx;
  logic                 slot_free;
  logic [CW:0]          rem_sh;
  logic [SW:0]          diff_d;
  logic [SW:0]          sum_avg;
  logic [PW-1:0]        product;
  logic [RW-1:0]        prod_rnd;
  logic signed [SW-1:0] ref_sel;
  logic signed [SW+1:0] take_diff;
  logic                 take_hit;
  logic [AW-1:0]        tacc_sum;
  logic [CW-1:0]        good_inc, seen_inc;

  assign ch_idx    = (CHANNELS > 1) ? CH_W'(item_r.channel) : '0;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rem_sh  = {rem_r, accum_r[AW-1]};
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + 34'(add_cin);

  always_comb begin
    if (state_r == S_DIV) begin
      add_a   = 33'(rem_sh);
      add_b   = ~(33'(rem_sh) ^ 33'(rem_sh) | 33'(good_r));
      add_cin = 1'b1;
    end else begin
      add_a   = {1'b0, hi_r};
      add_b   = {1'b0, gain_r};
      add_cin = 1'b0;
    end
  end

  assign diff_d   = {1'b0, item_r.raw_sample} - {1'b0, offset_r[ch_idx]};
  assign product  = {hi_r, lo_r};
  assign prod_rnd = product[PW-1:16] + RW'(product[15]);
  assign sum_avg  = {smooth_r[ch_idx][SW-1], smooth_r[ch_idx]} + {scaled_r[SW-1], scaled_r};
  assign ref_sel  = (ch_idx == '0) ? ref_a_r : ref_b_r;
  assign take_diff = $signed({{2{ref_sel[SW-1]}}, ref_sel})
                   - $signed({{2{res_w_r[SW-1]}}, res_w_r});
  assign take_hit = (take_diff >= $signed({3'b000, thr_r})) && !item_r.ir_level;
  assign tacc_sum = accum_r + AW'(item_r.raw_sample);
  assign good_inc = good_r + CW'(1);
  assign seen_inc = seen_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    offset_nxt    = offset_r;
    smooth_nxt    = smooth_r;
    seeded_nxt    = seeded_r;
    accum_nxt     = accum_r;
    good_nxt      = good_r;
    seen_nxt      = seen_r;
    item_nxt      = item_r;
    step_nxt      = step_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    scaled_nxt    = scaled_r;
    res_w_nxt     = res_w_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = in_data.req_type ? S_TACC : S_PREP;
        end
      end
      S_PREP: begin
        done_nxt = 1'b0;
        step_nxt = '0;
        hi_nxt   = '0;
        neg_nxt  = diff_d[SW];
        lo_nxt   = diff_d[SW] ? MW'(~diff_d + 1'b1) : MW'(diff_d);
        if (item_r.timed_out) begin
          res_w_nxt = seeded_r[ch_idx] ? smooth_r[ch_idx] : '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (lo_r[0]) begin
          hi_nxt = add_sum[32:1];
          lo_nxt = {add_sum[0], lo_r[MW-1:1]};
        end else begin
          hi_nxt = {1'b0, hi_r[lcwc_pkg::GAIN_W-1:1]};
          lo_nxt = {hi_r[0], lo_r[MW-1:1]};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == lcwc_pkg::STEP_W'(MW - 1)) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        if (neg_r) begin
          scaled_nxt = (prod_rnd > RW'(24'h80_0000)) ? lcwc_pkg::SAT_NEG
                                                   : (~prod_rnd[SW-1:0]) + 1'b1;
        end else begin
          scaled_nxt = (prod_rnd > RW'(lcwc_pkg::SAT_POS)) ? lcwc_pkg::SAT_POS
                                                          : prod_rnd[SW-1:0];
        end
        state_nxt = S_FILT;
      end
      S_FILT: begin
        seeded_nxt[ch_idx] = 1'b1;
        if ((scaled_r > lcwc_pkg::DEAD_LO) && (scaled_r < lcwc_pkg::DEAD_HI)) begin
          smooth_nxt[ch_idx] = '0;
          res_w_nxt          = '0;
        end else if (!seeded_r[ch_idx]) begin
          smooth_nxt[ch_idx] = scaled_r;
          res_w_nxt          = scaled_r;
        end else begin
          smooth_nxt[ch_idx] = sum_avg[SW:1];
          res_w_nxt          = sum_avg[SW:1];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.weight        = res_w_r;
          out_data_nxt.take_detected = !item_r.req_type && take_hit;
          out_data_nxt.tare_done     = done_r;
          state_nxt                  = S_IDLE;
        end
      end
      S_TACC: begin
        res_w_nxt = '0;
        done_nxt  = 1'b0;
        seen_nxt  = seen_inc;
        if (!item_r.timed_out) begin
          accum_nxt = tacc_sum;
          good_nxt  = good_inc;
        end
        state_nxt = S_OUT;
        if (seen_inc >= CW'(TARE_SAMPLES)) begin
          if (good_nxt != '0) begin
            step_nxt  = '0;
            rem_nxt   = '0;
            state_nxt = S_DIV;
          end else begin
            accum_nxt = '0;
            seen_nxt  = '0;
            done_nxt  = 1'b1;
          end
        end
      end
      S_DIV: begin
        rem_nxt   = add_sum[33] ? add_sum[CW-1:0] : rem_sh[CW-1:0];
        accum_nxt = {accum_r[AW-2:0], add_sum[33]};
        step_nxt  = step_r + 1'b1;
        if (step_r == lcwc_pkg::STEP_W'(AW - 1)) begin
          state_nxt = S_TWR;
        end
      end
      S_TWR: begin
        offset_nxt[ch_idx] = accum_r[SW-1:0];
        accum_nxt          = '0;
        good_nxt           = '0;
        seen_nxt           = '0;
        done_nxt           = 1'b1;
        state_nxt          = S_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gain_r      <= lcwc_pkg::GAIN_RESET;
      ref_a_r     <= '0;
      ref_b_r     <= '0;
      thr_r       <= '0;
      seeded_r    <= '0;
      accum_r     <= '0;
      good_r      <= '0;
      seen_r      <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        offset_r[i] <= '0;
        smooth_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seeded_r    <= seeded_nxt;
      accum_r     <= accum_nxt;
      good_r      <= good_nxt;
      seen_r      <= seen_nxt;
      offset_r    <= offset_nxt;
      smooth_r    <= smooth_nxt;
      if (cfg_valid) begin
        case (lcwc_pkg::cfg_reg_t'(cfg_index))
          lcwc_pkg::REG_GAIN_RECIP: gain_r  <= cfg_data;
          lcwc_pkg::REG_REF_A:      ref_a_r <= cfg_data[SW-1:0];
          lcwc_pkg::REG_REF_B:      ref_b_r <= cfg_data[SW-1:0];
          lcwc_pkg::REG_TAKE_THR:   thr_r   <= cfg_data[lcwc_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    step_r     <= step_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    scaled_r   <= scaled_nxt;
    res_w_r    <= res_w_nxt;
    done_r     <= done_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/lcwc_checker.sv]
// port-level checks for the load cell weight conditioner, bound to the top level
// depends on lcwc_pkg and load_cell_weight_conditioner_defines.svh
`include "load_cell_weight_conditioner_defines.svh"

module lcwc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input lcwc_pkg::out_item_t            out_data
);

  // stalled item holds
  `LCWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "out item changed while stalled")

  // an accepted item keeps the block busy
  `LCWC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                    "input ready right after accept")

  // a result appears only after a busy cycle
  `LCWC_ASSERT_IMPL(a_result_from_busy, $rose(out_valid), !$past(in_ready),
                    "result without work")

  // tare results carry no weight and no take
  `LCWC_ASSERT_IMPL(a_tare_result_clean, out_valid && out_data.tare_done,
                    (out_data.weight == '0) && !out_data.take_detected,
                    "tare result with weight or take")

endmodule

bind load_cell_weight_conditioner lcwc_checker u_lcwc_checker (.*);
